/* rtl/core/ppnn_pkg.sv */
// Package for the prior-point nearest neighbor block.
// Holds the sizes, the controller-to-datapath command and status types.
package ppnn_pkg;

  localparam int MAX_POINTS    = 4096;
  localparam int MAX_NEIGHBORS = 16;
  localparam int MAX_DIMS      = 4;

  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int SLOT_W  = $clog2(MAX_NEIGHBORS);
  localparam int NB_W    = SLOT_W + 1;
  localparam int DIM_W   = 3;
  localparam int COORD_W = 16;
  localparam int POINT_W = COORD_W * MAX_DIMS;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_TOTAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE    = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              list_clr;
    logic [NB_W-1:0]   m;
    logic [DIM_W-1:0]  dims;
    logic [SLOT_W-1:0] sel;
  } ppnn_cmd_t;

  typedef struct packed {
    logic              pipe_busy;
    logic [ADDR_W-1:0] nb_idx;
  } ppnn_stat_t;

endpackage

/* rtl/core/ppnn_datapath.sv */
// Datapath: point memory, distance pipeline and the sorted nearest list.
// Depends on ppnn_pkg.
module ppnn_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ppnn_pkg::ppnn_cmd_t               cmd,
  input  logic [ppnn_pkg::POINT_W-1:0]      point_in,
  output ppnn_pkg::ppnn_stat_t              stat
);

  logic [ppnn_pkg::POINT_W-1:0] mem [ppnn_pkg::MAX_POINTS];

  logic [ppnn_pkg::POINT_W-1:0] q_r;
  logic [ppnn_pkg::POINT_W-1:0] rd_data_r;
  logic [ppnn_pkg::ADDR_W-1:0]  idx1_r, idx2_r, idx3_r;
  logic                         v1_r, v2_r, v3_r;
  logic [ppnn_pkg::SQ_W-1:0]    sq_r [ppnn_pkg::MAX_DIMS];
  logic [ppnn_pkg::SQ_W-1:0]    sq_nxt [ppnn_pkg::MAX_DIMS];
  logic [ppnn_pkg::DIST_W-1:0]  dist_r, dist_nxt;

  logic [ppnn_pkg::DIST_W-1:0]  best_d_r [ppnn_pkg::MAX_NEIGHBORS];
  logic [ppnn_pkg::ADDR_W-1:0]  best_i_r [ppnn_pkg::MAX_NEIGHBORS];
  logic [ppnn_pkg::NB_W-1:0]    cnt_r;
  logic [ppnn_pkg::MAX_NEIGHBORS-1:0] lt;
  logic                         ins;

  // Point memory: one write at accept, one registered read per scan cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= point_in;
      q_r              <= point_in;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  always_comb begin
    logic signed [ppnn_pkg::COORD_W:0]     df;
    logic signed [2*ppnn_pkg::COORD_W+1:0] pr;
    for (int d = 0; d < ppnn_pkg::MAX_DIMS; d++) begin
      df = (ppnn_pkg::COORD_W+1)'(signed'(q_r[d*ppnn_pkg::COORD_W +: ppnn_pkg::COORD_W]))
         - (ppnn_pkg::COORD_W+1)'(signed'(rd_data_r[d*ppnn_pkg::COORD_W +: ppnn_pkg::COORD_W]));
      pr = df * df;
      sq_nxt[d] = (d < int'(cmd.dims)) ? pr[ppnn_pkg::SQ_W-1:0] : '0;
    end
  end

  always_comb begin
    dist_nxt = '0;
    for (int d = 0; d < ppnn_pkg::MAX_DIMS; d++) begin
      dist_nxt = dist_nxt + ppnn_pkg::DIST_W'(sq_r[d]);
    end
  end

  // Slots at or beyond the fill count act as infinitely far.
  always_comb begin
    for (int p = 0; p < ppnn_pkg::MAX_NEIGHBORS; p++) begin
      lt[p] = (p >= int'(cnt_r)) || (dist_r < best_d_r[p]);
    end
    ins = v3_r && lt[ppnn_pkg::SLOT_W'(cmd.m - 1'b1)];
  end

  always_ff @(posedge clk) begin
    sq_r   <= sq_nxt;
    dist_r <= dist_nxt;
    idx1_r <= cmd.rd_addr;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    if (ins) begin
      for (int p = 0; p < ppnn_pkg::MAX_NEIGHBORS; p++) begin
        if (p > 0 && lt[p-1]) begin
          best_d_r[p] <= best_d_r[p-1];
          best_i_r[p] <= best_i_r[p-1];
        end else if (lt[p]) begin
          best_d_r[p] <= dist_r;
          best_i_r[p] <= idx3_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.list_clr) begin
        cnt_r <= '0;
      end else if (ins && cnt_r < cmd.m) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign stat.pipe_busy = v1_r | v2_r | v3_r;
  assign stat.nb_idx    = best_i_r[cmd.sel];

endmodule

/* rtl/core/ppnn_ctrl.sv */
// Controller: configuration registers, point counter, scan and emit sequencing
// and the output register. Depends on ppnn_pkg.
module ppnn_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ppnn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppnn_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ppnn_pkg::ADDR_W-1:0]       out_query,
  output logic [ppnn_pkg::CNT_W-1:0]        out_nb,
  output logic                              out_last,
  output ppnn_pkg::ppnn_cmd_t               cmd,
  input  ppnn_pkg::ppnn_stat_t              stat
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_EMIT} state_t;

  state_t                      state_r;
  logic [4:0]                  nc_r;
  logic [ppnn_pkg::CNT_W-1:0]  total_r;
  logic [ppnn_pkg::DIM_W-1:0]  dims_cfg_r;
  logic [ppnn_pkg::CNT_W-1:0]  seen_r;
  logic [ppnn_pkg::ADDR_W-1:0] i_r, j_r;
  logic [ppnn_pkg::NB_W-1:0]   m_r, k_r, m_nxt;
  logic [ppnn_pkg::DIM_W-1:0]  dims_r, dims_nxt;
  logic [ppnn_pkg::CNT_W-1:0]  sent_r;
  logic                        scan_r;
  logic                        out_valid_r, out_last_r;
  logic [ppnn_pkg::ADDR_W-1:0] out_query_r;
  logic [ppnn_pkg::CNT_W-1:0]  out_nb_r;
  logic [ppnn_pkg::CNT_W-1:0]  limit;
  logic                        take;

  always_comb begin
    limit = (total_r > ppnn_pkg::CNT_W'(ppnn_pkg::MAX_POINTS))
          ? ppnn_pkg::CNT_W'(ppnn_pkg::MAX_POINTS) : total_r;
    if (nc_r == '0) begin
      m_nxt = ppnn_pkg::NB_W'(1);
    end else if (nc_r > 5'(ppnn_pkg::MAX_NEIGHBORS)) begin
      m_nxt = ppnn_pkg::NB_W'(ppnn_pkg::MAX_NEIGHBORS);
    end else begin
      m_nxt = ppnn_pkg::NB_W'(nc_r);
    end
    dims_nxt = (dims_cfg_r > ppnn_pkg::DIM_W'(ppnn_pkg::MAX_DIMS))
             ? ppnn_pkg::DIM_W'(ppnn_pkg::MAX_DIMS) : dims_cfg_r;
    take = (state_r == ST_IDLE) && in_valid && (seen_r < limit);
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.wr_en    = take;
    cmd.wr_addr  = seen_r[ppnn_pkg::ADDR_W-1:0];
    cmd.rd_en    = (state_r == ST_SCAN);
    cmd.rd_addr  = j_r;
    cmd.list_clr = take;
    cmd.m        = m_r;
    cmd.dims     = dims_r;
    cmd.sel      = ppnn_pkg::SLOT_W'(m_r - k_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nc_r        <= 5'd8;
      total_r     <= ppnn_pkg::CNT_W'(4096);
      dims_cfg_r  <= ppnn_pkg::DIM_W'(2);
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      i_r <= '0; j_r <= '0; k_r <= '0; m_r <= ppnn_pkg::NB_W'(1);
      dims_r <= '0; sent_r <= '0; scan_r <= 1'b0;
      out_last_r <= 1'b0; out_query_r <= '0; out_nb_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          ppnn_pkg::REG_NEIGHBOR_COUNT: nc_r <= cfg_wdata[4:0];
          ppnn_pkg::REG_POINT_TOTAL:    total_r <= cfg_wdata;
          ppnn_pkg::REG_DIMS_IN_USE:    dims_cfg_r <= cfg_wdata[ppnn_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            i_r    <= seen_r[ppnn_pkg::ADDR_W-1:0];
            seen_r <= seen_r + 1'b1;
            m_r    <= m_nxt;
            dims_r <= dims_nxt;
            sent_r <= total_r;
            j_r    <= '0;
            k_r    <= '0;
            scan_r <= (seen_r > ppnn_pkg::CNT_W'(m_nxt));
            state_r <= (seen_r > ppnn_pkg::CNT_W'(m_nxt)) ? ST_SCAN : ST_EMIT;
          end
        end
        ST_SCAN: begin
          j_r <= j_r + 1'b1;
          if (j_r == i_r - 1'b1) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat.pipe_busy) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            if (k_r != m_r) begin
              out_valid_r <= 1'b1;
              out_query_r <= i_r;
              out_last_r  <= (k_r == m_r - 1'b1);
              if (scan_r) begin
                out_nb_r <= {1'b0, stat.nb_idx};
              end else if (ppnn_pkg::ADDR_W'(k_r) < i_r) begin
                out_nb_r <= ppnn_pkg::CNT_W'(k_r);
              end else begin
                out_nb_r <= sent_r;
              end
              k_r <= k_r + 1'b1;
            end else begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_query = out_query_r;
  assign out_nb    = out_nb_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/core/prior_point_nearest_neighbors.sv */
// Top level of the prior-point nearest neighbor block.
// Depends on ppnn_pkg, ppnn_ctrl and ppnn_datapath.
//
// Each accepted point is stored under the next query index and answered with
// neighbor_count items (clamped to 1..16), the last one carrying tlast. When
// the query index i exceeds neighbor_count, every earlier point is read from
// the point memory at one point per cycle, its squared distance is formed in
// a three-stage pipeline and merged into a sorted list; the run then lists
// the nearest points farthest first. In that case the scan over the single
// point memory read port sets how long an item takes. For smaller indices
// the run lists 0..i-1 and pads with point_total. Result items go out one
// per cycle while out_tready holds. The block takes a new point only after
// the previous run is fully delivered. Once point_total points (at most
// 4096) have been taken, further points are accepted and dropped silently.
// The memory needs no clearing: only entries already written are read.
module prior_point_nearest_neighbors (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // coord_0, coord_1, coord_2, coord_3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // query_index, neighbor_index, zero fill
  output logic        out_tlast
);

  ppnn_pkg::ppnn_cmd_t  cmd;
  ppnn_pkg::ppnn_stat_t stat;
  logic [ppnn_pkg::ADDR_W-1:0] q;
  logic [ppnn_pkg::CNT_W-1:0]  nb;

  ppnn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_query (q),
    .out_nb    (nb),
    .out_last  (out_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

  ppnn_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .point_in (in_tdata),
    .stat     (stat)
  );

  // Query index in the low bits, the neighbor index above it.
  assign out_tdata = {7'd0, nb, q};

endmodule

/* rtl/core/ppnn_checker.sv */
// Port-level checker for the prior-point nearest neighbor block, with bind.
// Depends only on the top level's ports.
module ppnn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a run is in flight");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("item shown after the end of a run");

  a_run_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tdata[11:0] == $past(out_tdata[11:0]))
    else $error("run broken or query index changed");

endmodule

bind prior_point_nearest_neighbors ppnn_checker u_ppnn_checker (.*);

/* tb/prior_point_nearest_neighbors_tb.sv */
`timescale 1ns / 100ps
// Testbench for prior_point_nearest_neighbors: drives points, predicts each neighbor list.
// Depends on ppnn_pkg and the block's RTL only.
module prior_point_nearest_neighbors_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  always #4 clk = ~clk;

  prior_point_nearest_neighbors u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // One expected neighbor item.
  typedef struct packed {
    logic [11:0] query;
    logic [12:0] neighbor;
    logic        last;
  } nb_item_t;

  // Predictor state: shadow registers and a copy of every stored point.
  logic [4:0]  nbr_count_q;
  logic [12:0] point_total_q;
  logic [2:0]  dims_q;
  logic [63:0] stored_points[ppnn_pkg::MAX_POINTS];
  int unsigned stored_count;

  nb_item_t expected_nbrs[$];
  int errors = 0;
  int results_seen = 0;
  int points_sent = 0;
  int idle_pct = 30;
  int idle_cycles = 0;
  bit busy_done = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint signed coord_at(input logic [63:0] p, input int d);
    logic signed [15:0] c;
    c = p[16*d +: 16];
    return longint'(c);
  endfunction

  // Works out the list of neighbor items that one accepted point produces.
  task automatic predict_neighbors(input logic [63:0] pt);
    int unsigned lim, m, dims, qi, cnt, pos;
    logic [35:0] best_d[ppnn_pkg::MAX_NEIGHBORS];
    int unsigned best_i[ppnn_pkg::MAX_NEIGHBORS];
    logic [35:0] dist_val;
    longint signed df;
    nb_item_t it;
    lim = (point_total_q < ppnn_pkg::MAX_POINTS) ? point_total_q : ppnn_pkg::MAX_POINTS;
    if (stored_count >= lim) return;
    m = nbr_count_q;
    if (m < 1) m = 1;
    if (m > ppnn_pkg::MAX_NEIGHBORS) m = ppnn_pkg::MAX_NEIGHBORS;
    dims = (dims_q > ppnn_pkg::MAX_DIMS) ? ppnn_pkg::MAX_DIMS : dims_q;
    qi = stored_count;
    stored_points[qi] = pt;
    stored_count++;
    if (qi > m) begin
      cnt = 0;
      for (int j = 0; j < qi; j++) begin
        dist_val = '0;
        for (int d = 0; d < dims; d++) begin
          df = coord_at(pt, d) - coord_at(stored_points[j], d);
          dist_val += 36'(df * df);
        end
        if (cnt == m && !(dist_val < best_d[m-1])) continue;
        if (cnt < m) cnt++;
        pos = cnt - 1;
        while (pos > 0 && dist_val < best_d[pos-1]) begin
          best_d[pos] = best_d[pos-1];
          best_i[pos] = best_i[pos-1];
          pos--;
        end
        best_d[pos] = dist_val;
        best_i[pos] = j;
      end
      for (int k = 0; k < m; k++) begin
        it.query = qi[11:0];
        it.neighbor = best_i[m-1-k][12:0];
        it.last = (k == m - 1);
        expected_nbrs.push_back(it);
      end
    end else begin
      for (int k = 0; k < m; k++) begin
        it.query = qi[11:0];
        it.neighbor = (k < qi) ? 13'(k) : point_total_q;
        it.last = (k == m - 1);
        expected_nbrs.push_back(it);
      end
    end
  endtask

  // Sends one point; random idle cycles sit in front of it.
  task automatic send_point(input logic [15:0] c0, c1, c2, c3);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {c3, c2, c1, c0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_neighbors({c3, c2, c1, c0});
    points_sent++;
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted item has come, then lets the block settle.
  task automatic drain();
    while (expected_nbrs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      ppnn_pkg::REG_NEIGHBOR_COUNT: nbr_count_q = val[4:0];
      ppnn_pkg::REG_POINT_TOTAL:    point_total_q = val;
      ppnn_pkg::REG_DIMS_IN_USE:    dims_q = val[2:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(15)) - 16'd8;
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Extremes of the coordinates, first point, sentinel padding and distance ties.
  task automatic test_directed();
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_point(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555);
    for (int i = 0; i < 6; i++) send_point(16'h0003, 16'h0003, 16'h0000, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h1234, 16'hFEDC);
    send_point(16'hFFFD, 16'hFFFD, 16'h0000, 16'h0000);
    drain();
  endtask

  // A point set that fills up, then is opened again by a larger total.
  task automatic test_set_full();
    write_reg(ppnn_pkg::REG_NEIGHBOR_COUNT, 13'd16);
    write_reg(ppnn_pkg::REG_DIMS_IN_USE, 13'd4);
    write_reg(ppnn_pkg::REG_POINT_TOTAL, 13'(stored_count + 20));
    send_random(24);
    drain();
    write_reg(ppnn_pkg::REG_POINT_TOTAL, 13'd4096);
  endtask

  // Zero and out-of-range register values: count 0 acts as 1, dims 0 ties all.
  task automatic test_odd_settings();
    write_reg(ppnn_pkg::REG_NEIGHBOR_COUNT, 13'd0);
    write_reg(ppnn_pkg::REG_DIMS_IN_USE, 13'd0);
    send_random(4);
    drain();
    write_reg(ppnn_pkg::REG_NEIGHBOR_COUNT, 13'd31);
    write_reg(ppnn_pkg::REG_DIMS_IN_USE, 13'd7);
    send_random(4);
    drain();
    write_reg(ppnn_pkg::REG_NEIGHBOR_COUNT, 13'd1);
    write_reg(ppnn_pkg::REG_DIMS_IN_USE, 13'd1);
    send_random(6);
    drain();
  endtask

  // Bulk random points over several settings, one phase with no idling.
  task automatic test_random();
    write_reg(ppnn_pkg::REG_NEIGHBOR_COUNT, 13'($urandom_range(1, 16)));
    write_reg(ppnn_pkg::REG_DIMS_IN_USE, 13'($urandom_range(1, 4)));
    send_random(35);
    drain();
    idle_pct = 0;
    write_reg(ppnn_pkg::REG_NEIGHBOR_COUNT, 13'd5);
    write_reg(ppnn_pkg::REG_DIMS_IN_USE, 13'd3);
    send_random(30);
    drain();
    idle_pct = 30;
    write_reg(ppnn_pkg::REG_NEIGHBOR_COUNT, 13'd12);
    write_reg(ppnn_pkg::REG_DIMS_IN_USE, 13'd2);
    send_random(25);
  endtask

  // Result side: random back-pressure, with a calm stretch when the sender runs flat out.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= 30);
  end

  // Checks every accepted result item against the oldest prediction.
  always @(posedge clk) begin
    nb_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_nbrs.size() == 0) begin
        report_mismatch($sformatf("unexpected item q=%0d nb=%0d",
                                  out_tdata[11:0], out_tdata[24:12]));
      end else begin
        want = expected_nbrs.pop_front();
        if (out_tdata[11:0] !== want.query)
          report_mismatch($sformatf("query %0d, want %0d", out_tdata[11:0], want.query));
        if (out_tdata[24:12] !== want.neighbor)
          report_mismatch($sformatf("q=%0d neighbor %0d, want %0d",
                                    want.query, out_tdata[24:12], want.neighbor));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("q=%0d tlast %0b, want %0b",
                                    want.query, out_tlast, want.last));
      end
    end
  end

  // Watchdog: fails the run when no point or result item is handed over for longer than the idle limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    nbr_count_q = 5'd8;
    point_total_q = 13'd4096;
    dims_q = 3'd2;
    stored_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_set_full();
    test_odd_settings();
    test_random();
    drain();
    $display("Sent %0d points, checked %0d neighbor items (%0d stored).",
             points_sent, results_seen, stored_count);
    $display("Covered sentinel runs, ties, full set, odd register values.");
    if (errors == 0 && expected_nbrs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/ppnn_pkg.sv
rtl/core/ppnn_datapath.sv
rtl/core/ppnn_ctrl.sv
rtl/core/prior_point_nearest_neighbors.sv
rtl/core/ppnn_checker.sv
tb/prior_point_nearest_neighbors_tb.sv
